/* sv/cpvm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color plane video memory package
// Shared constants, codes and types of the three-plane video memory.
// ----------------------------------------------------------------------------
package cpvm_pkg;

    localparam int PAGE_COUNT_DEF = 4;
    localparam int PAGE_SIZE_DEF  = 16384;

    localparam int PLANE_COUNT = 3;
    localparam int PLANE_W     = 8;
    localparam int WORD_W      = PLANE_COUNT * PLANE_W;
    localparam int ADDRESS_W   = 14;
    localparam int PAGE_W      = 2;
    localparam int CTRL_W      = 8;
    localparam int LIN_W       = 16;

    localparam int CTRL_SET_BIT   = 0;
    localparam int CTRL_WSEL_LSB  = 1;
    localparam int CTRL_RSEL_LSB  = 4;
    localparam int CTRL_COLOR_BIT = 7;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } opcode_t;

    typedef enum logic {
        REG_COLOR_CONTROL = 1'b0,
        REG_ACCESS_PAGE   = 1'b1
    } reg_index_t;

    typedef logic [WORD_W-1:0] word_t;

endpackage

/* sv/cpvm_plane_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color plane video memory plane logic
// Computes the updated three-plane word of a write and the combined byte of a
// read from one stored word and the color control register.
// ----------------------------------------------------------------------------
module cpvm_plane_alu (
    input  logic [cpvm_pkg::CTRL_W-1:0]  color_control,
    input  logic [cpvm_pkg::PLANE_W-1:0] mask,
    input  cpvm_pkg::word_t              word,
    output cpvm_pkg::word_t              word_next,
    output logic [cpvm_pkg::PLANE_W-1:0] read_byte
);

    logic color;
    logic setb;

    assign color = color_control[cpvm_pkg::CTRL_COLOR_BIT];
    assign setb  = color_control[cpvm_pkg::CTRL_SET_BIT];

    always_comb
    begin
        logic [cpvm_pkg::PLANE_W-1:0] plane;
        logic wsel;
        logic rsel;
        read_byte = '0;
        word_next = word;
        for (int p = 0; p < cpvm_pkg::PLANE_COUNT; p++)
        begin
            plane = word[p*cpvm_pkg::PLANE_W +: cpvm_pkg::PLANE_W];
            wsel  = color_control[cpvm_pkg::CTRL_WSEL_LSB + p];
            rsel  = color_control[cpvm_pkg::CTRL_RSEL_LSB + p];
            if (color)
            begin
                word_next[p*cpvm_pkg::PLANE_W +: cpvm_pkg::PLANE_W] =
                    wsel ? (plane | mask) : (plane & ~mask);
                read_byte = read_byte | (rsel ? ~plane : plane);
            end
            else
            begin
                if (!wsel)
                begin
                    word_next[p*cpvm_pkg::PLANE_W +: cpvm_pkg::PLANE_W] =
                        setb ? (plane | mask) : (plane & ~mask);
                end
                if (rsel)
                begin
                    read_byte = read_byte | plane;
                end
            end
        end
    end

endmodule

/* sv/color_plane_video_memory.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color plane video memory
// Three-plane bitmap store with per-plane write and read combining under a
// color control register and a selected access page.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  input     in_valid / in_ready    opcode, address, write_data
//  output    out_valid / out_ready  read_data
//  config    cfg_write              cfg_index, cfg_data
//
// An item is taken every cycle unless clearing or a stalled read holds it;
// a read's plane memory word is registered when the item is taken, and the
// merged byte is then registered from it as the read result.
// After reset a clearing pass zeroes the plane memory, one word per cycle over
// all PAGE_COUNT * PAGE_SIZE words, and in_ready stays low until it ends.
// A stalled read result holds the merge stage, which stops new items.
// ----------------------------------------------------------------------------
module color_plane_video_memory #(
    parameter int PAGE_COUNT = cpvm_pkg::PAGE_COUNT_DEF,
    parameter int PAGE_SIZE  = cpvm_pkg::PAGE_SIZE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic                            cfg_index,
    input  logic [cpvm_pkg::CTRL_W-1:0]     cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            opcode,
    input  logic [cpvm_pkg::ADDRESS_W-1:0]  address,
    input  logic [cpvm_pkg::PLANE_W-1:0]    write_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [cpvm_pkg::PLANE_W-1:0]    read_data
);

    localparam int DEPTH  = PAGE_COUNT * PAGE_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [cpvm_pkg::CTRL_W-1:0] color_control_reg;
    logic [cpvm_pkg::PAGE_W-1:0] access_page_reg;

    logic                clearing_reg;
    logic [ADDR_W-1:0]   clr_cnt_reg;

    logic                s1_valid_reg;
    cpvm_pkg::opcode_t   s1_op_reg;
    logic [ADDR_W-1:0]   s1_idx_reg;
    logic [cpvm_pkg::PLANE_W-1:0] s1_mask_reg;

    logic                fwd_valid_reg;
    logic [ADDR_W-1:0]   fwd_idx_reg;
    cpvm_pkg::word_t     fwd_word_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [cpvm_pkg::PLANE_W-1:0] read_data_reg;

    cpvm_pkg::word_t     mem [DEPTH];
    cpvm_pkg::word_t     mem_rd_reg;

    logic                in_accept;
    logic                s1_adv;
    logic                s1_write;
    logic [cpvm_pkg::ADDRESS_W-1:0] offset;
    logic [cpvm_pkg::PAGE_W-1:0]    page;
    logic [cpvm_pkg::LIN_W-1:0]     lin;
    logic [ADDR_W-1:0]   in_idx;

    cpvm_pkg::word_t     base_word;
    cpvm_pkg::word_t     new_word;
    logic [cpvm_pkg::PLANE_W-1:0] merged;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    cpvm_pkg::word_t     mem_wdata;

    assign offset = address & cpvm_pkg::ADDRESS_W'(PAGE_SIZE - 1);
    assign page   = access_page_reg & cpvm_pkg::PAGE_W'(PAGE_COUNT - 1);
    assign lin    = cpvm_pkg::LIN_W'(page) * cpvm_pkg::LIN_W'(PAGE_SIZE)
                  + cpvm_pkg::LIN_W'(offset);
    assign in_idx = ({1'b0, lin} < (cpvm_pkg::LIN_W + 1)'(DEPTH)) ? lin[ADDR_W-1:0] : '0;

    assign s1_write  = (s1_op_reg == cpvm_pkg::OP_WRITE);
    assign s1_adv    = s1_valid_reg && (s1_write || !out_valid_reg || out_ready);
    assign in_ready  = !clearing_reg && (!s1_valid_reg || s1_adv);
    assign in_accept = in_valid && in_ready;

    assign base_word = (fwd_valid_reg && (fwd_idx_reg == s1_idx_reg)) ? fwd_word_reg
                                                                      : mem_rd_reg;

    cpvm_plane_alu u_alu (
        .color_control (color_control_reg),
        .mask          (s1_mask_reg),
        .word          (base_word),
        .word_next     (new_word),
        .read_byte     (merged)
    );

    assign mem_we    = clearing_reg || (s1_adv && s1_write);
    assign mem_waddr = clearing_reg ? clr_cnt_reg : s1_idx_reg;
    assign mem_wdata = clearing_reg ? '0 : new_word;

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (s1_adv && !s1_write)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_control_reg <= '0;
            access_page_reg   <= '0;
            clearing_reg      <= 1'b1;
            clr_cnt_reg       <= '0;
            s1_valid_reg      <= 1'b0;
            fwd_valid_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cpvm_pkg::reg_index_t'(cfg_index))
                    cpvm_pkg::REG_COLOR_CONTROL: color_control_reg <= cfg_data;
                    cpvm_pkg::REG_ACCESS_PAGE:
                        access_page_reg <= cfg_data[cpvm_pkg::PAGE_W-1:0];
                    default: ;
                endcase
            end
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (in_accept)
            begin
                s1_valid_reg  <= 1'b1;
                fwd_valid_reg <= s1_adv && s1_write;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg   <= cpvm_pkg::opcode_t'(opcode);
            s1_idx_reg  <= in_idx;
            s1_mask_reg <= write_data;
            fwd_idx_reg  <= s1_idx_reg;
            fwd_word_reg <= new_word;
        end
        if (s1_adv && !s1_write)
        begin
            read_data_reg <= merged;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (in_accept)
        begin
            mem_rd_reg <= mem[in_idx];
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

endmodule

/* sv/cpvm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color plane video memory checker
// Port-level checks on the result channel and the clearing pass, bound to the
// top level.
// ----------------------------------------------------------------------------
module cpvm_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            opcode,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [cpvm_pkg::PLANE_W-1:0]    read_data
);

    logic acc_write;
    logic acc_read;

    assign acc_write = in_valid && in_ready && (opcode == cpvm_pkg::OP_WRITE);
    assign acc_read  = in_valid && in_ready && (opcode == cpvm_pkg::OP_READ);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data))
        else $error("A stalled result item changed or dropped.");

    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_ready)
        else $error("An item was taken before the plane memory was cleared.");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        acc_write ##1 !out_valid |=> !out_valid)
        else $error("A write item produced a result item.");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        acc_read ##1 !out_valid |=> out_valid)
        else $error("A read item did not produce its result item in time.");

endmodule

bind color_plane_video_memory cpvm_checker u_cpvm_checker (.*);
